// ===== hdl/rro_pkg.sv =====
// Package for the rotated rectangle overlap block: widths, item types,
// CORDIC arctangent table. No dependencies.
package rro_pkg;

   localparam int CoordW      = 24;
   localparam int AngleW      = 16;
   localparam int CordicSteps = 16;
   localparam int CordicW     = 34;   // Q30 plus growth and sign
   localparam int TrigW       = 18;   // Q16 sine/cosine, signed
   localparam int DiffW       = 25;
   localparam int ProdW       = 43;   // 25 x 18 signed product
   localparam int SumW        = 48;
   localparam int FifoDepth   = 4;
   localparam int FifoAw      = 2;
   localparam int FifoCw      = 3;
   localparam int BackLat     = CordicSteps + 1;   // CORDIC pipe depth
   localparam int ResDepth    = 32;   // result ring entries, also the credits
   localparam int ResAw       = 5;
   localparam int CredW       = 6;

   typedef struct packed {
      logic signed [CoordW-1:0] ax;
      logic signed [CoordW-1:0] ay;
      logic [CoordW-1:0]        wa;
      logic [CoordW-1:0]        ha;
      logic [AngleW-1:0]        ta;
      logic signed [CoordW-1:0] bx;
      logic signed [CoordW-1:0] by;
      logic [CoordW-1:0]        wb;
      logic [CoordW-1:0]        hb;
      logic [AngleW-1:0]        tb;
   } item_type;

   // front -> back: differences, sizes and angles
   typedef struct packed {
      logic signed [DiffW-1:0] dx;
      logic signed [DiffW-1:0] dy;
      logic [CoordW-1:0]       wa;
      logic [CoordW-1:0]       ha;
      logic [CoordW-1:0]       wb;
      logic [CoordW-1:0]       hb;
      logic [AngleW-1:0]       ta;
      logic [AngleW-1:0]       tb;
      logic [AngleW-1:0]       td;
   } work_type;

   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

endpackage

// ===== hdl/rro_front.sv =====
// Front end: registers the item beat, forms centre difference and angle delta.
// Depends on rro_pkg.
module rro_front import rro_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output work_type out_work
);
   logic     valid_ff;
   work_type work_ff, work_in;

   always_comb begin
      work_in.dx = DiffW'(in_item.bx) - DiffW'(in_item.ax);
      work_in.dy = DiffW'(in_item.by) - DiffW'(in_item.ay);
      work_in.wa = in_item.wa;
      work_in.ha = in_item.ha;
      work_in.wb = in_item.wb;
      work_in.hb = in_item.hb;
      work_in.ta = in_item.ta;
      work_in.tb = in_item.tb;
      work_in.td = in_item.tb - in_item.ta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
endmodule

// ===== hdl/rro_fifo.sv =====
// Small queue between front and back.
// Depends on rro_pkg.
module rro_fifo import rro_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [$bits(work_type):0] push_data,
   input  logic                     pop,
   output logic                     empty,
   output logic [FifoCw-1:0]        count,
   output logic [$bits(work_type):0] pop_data
);
   logic [$bits(work_type):0] mem_ff [FifoDepth];
   logic [FifoAw-1:0] wr_ff, rd_ff;
   logic [FifoCw-1:0] cnt_ff;
   logic do_pop;

   assign empty    = (cnt_ff == '0);
   assign do_pop   = pop && !empty;
   assign count    = cnt_ff;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + FifoCw'(push) - FifoCw'(do_pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

// ===== hdl/rro_cordic.sv =====
// Pipelined rotation-mode CORDIC, one step per stage, Q16 cos/sin out.
// Depends on rro_pkg.
module rro_cordic import rro_pkg::*; (
   input  logic                    clock,
   input  logic [AngleW-1:0]       angle,
   output logic signed [TrigW-1:0] cos_out,
   output logic signed [TrigW-1:0] sin_out
);
   logic signed [CordicW-1:0] x_ff [CordicSteps+1];
   logic signed [CordicW-1:0] y_ff [CordicSteps+1];
   logic signed [CordicW-1:0] z_ff [CordicSteps+1];
   logic [1:0]                q_ff [CordicSteps+1];
   logic [31:0] u;
   logic signed [CordicW-1:0] cr, sr;

   assign u = {angle, {(32-AngleW){1'b0}}} + 32'h20000000;

   always_ff @(posedge clock) begin
      x_ff[0] <= CordicW'(32'h26DD3B6A);
      y_ff[0] <= '0;
      z_ff[0] <= CordicW'($signed({1'b0, u[29:0]})) - CordicW'(32'h20000000);
      q_ff[0] <= u[31:30];
      for (int i = 0; i < CordicSteps; i++) begin
         q_ff[i+1] <= q_ff[i];
         if (!z_ff[i][CordicW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - CordicW'(atan_turns(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + CordicW'(atan_turns(i));
         end
      end
   end

   always_comb begin
      cr = (x_ff[CordicSteps] + CordicW'(8192)) >>> 14;
      sr = (y_ff[CordicSteps] + CordicW'(8192)) >>> 14;
      case (q_ff[CordicSteps])
         2'd0: begin cos_out = TrigW'(cr);  sin_out = TrigW'(sr);  end
         2'd1: begin cos_out = -TrigW'(sr); sin_out = TrigW'(cr);  end
         2'd2: begin cos_out = -TrigW'(cr); sin_out = -TrigW'(sr); end
         default: begin cos_out = TrigW'(sr); sin_out = -TrigW'(cr); end
      endcase
   end
endmodule

// ===== hdl/rro_back.sv =====
// Back end: three CORDIC pipes, then projections and the four axis tests.
// Depends on rro_pkg, rro_cordic.
module rro_back import rro_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_work,
   output logic     out_valid,
   output logic     out_hit
);
   logic signed [TrigW-1:0] ca, sa, cb, sb, cd, sd;
   logic [BackLat-1:0] v_ff;
   work_type w_ff [BackLat];

   rro_cordic u_ca (.clock(clock), .angle(in_work.ta), .cos_out(ca), .sin_out(sa));
   rro_cordic u_cb (.clock(clock), .angle(in_work.tb), .cos_out(cb), .sin_out(sb));
   rro_cordic u_cd (.clock(clock), .angle(in_work.td), .cos_out(cd), .sin_out(sd));

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[BackLat-2:0], in_valid};
      w_ff[0] <= in_work;
      for (int i = 1; i < BackLat; i++) w_ff[i] <= w_ff[i-1];
   end

   // stage A: products
   work_type wk;
   logic signed [ProdW-1:0] p_ff [8];
   logic [TrigW-1:0] acd, asd;
   logic [TrigW-1:0] acd_ff, asd_ff;
   logic va_ff;
   work_type wa_ff;
   assign wk  = w_ff[BackLat-1];
   assign acd = cd[TrigW-1] ? TrigW'(-cd) : TrigW'(cd);
   assign asd = sd[TrigW-1] ? TrigW'(-sd) : TrigW'(sd);

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else       va_ff <= v_ff[BackLat-1];
      p_ff[0] <= wk.dx * ca; p_ff[1] <= wk.dy * sa;
      p_ff[2] <= wk.dx * sa; p_ff[3] <= wk.dy * ca;
      p_ff[4] <= wk.dx * cb; p_ff[5] <= wk.dy * sb;
      p_ff[6] <= wk.dx * sb; p_ff[7] <= wk.dy * cb;
      acd_ff <= acd; asd_ff <= asd;
      wa_ff  <= wk;
   end

   // stage B: width/height extent products and projection sums
   logic [SumW-1:0] wacd_ff, wasd_ff, hacd_ff, hasd_ff;
   logic [SumW-1:0] wbcd_ff, wbsd_ff, hbcd_ff, hbsd_ff;
   logic signed [SumW-1:0] pr_ff [4];
   logic [CoordW-1:0] wa2_ff, ha2_ff, wb2_ff, hb2_ff;
   logic vb_ff;

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else       vb_ff <= va_ff;
      wacd_ff <= SumW'(wa_ff.wa) * SumW'(acd_ff); wasd_ff <= SumW'(wa_ff.wa) * SumW'(asd_ff);
      hacd_ff <= SumW'(wa_ff.ha) * SumW'(acd_ff); hasd_ff <= SumW'(wa_ff.ha) * SumW'(asd_ff);
      wbcd_ff <= SumW'(wa_ff.wb) * SumW'(acd_ff); wbsd_ff <= SumW'(wa_ff.wb) * SumW'(asd_ff);
      hbcd_ff <= SumW'(wa_ff.hb) * SumW'(acd_ff); hbsd_ff <= SumW'(wa_ff.hb) * SumW'(asd_ff);
      pr_ff[0] <= SumW'(p_ff[0]) + SumW'(p_ff[1]);
      pr_ff[1] <= SumW'(p_ff[3]) - SumW'(p_ff[2]);
      pr_ff[2] <= SumW'(p_ff[4]) + SumW'(p_ff[5]);
      pr_ff[3] <= SumW'(p_ff[7]) - SumW'(p_ff[6]);
      wa2_ff <= wa_ff.wa; ha2_ff <= wa_ff.ha;
      wb2_ff <= wa_ff.wb; hb2_ff <= wa_ff.hb;
   end

   // stage C: compare
   logic [SumW:0] lhs [4];
   logic [SumW:0] rhs [4];
   logic hit_ff, vc_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lhs[k] = pr_ff[k][SumW-1] ? {(SumW+1)'(-pr_ff[k])} << 1
                                   : {(SumW+1)'(pr_ff[k])} << 1;
      end
      rhs[0] = {(SumW+1)'(wa2_ff) << 16} + (SumW+1)'(wbcd_ff) + (SumW+1)'(hbsd_ff);
      rhs[1] = {(SumW+1)'(ha2_ff) << 16} + (SumW+1)'(wbsd_ff) + (SumW+1)'(hbcd_ff);
      rhs[2] = {(SumW+1)'(wb2_ff) << 16} + (SumW+1)'(wacd_ff) + (SumW+1)'(hasd_ff);
      rhs[3] = {(SumW+1)'(hb2_ff) << 16} + (SumW+1)'(wasd_ff) + (SumW+1)'(hacd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vb_ff;
      hit_ff <= (lhs[0] <= rhs[0]) && (lhs[1] <= rhs[1]) &&
                (lhs[2] <= rhs[2]) && (lhs[3] <= rhs[3]);
   end

   assign out_valid = vc_ff;
   assign out_hit   = hit_ff;
endmodule

// ===== hdl/rotated_rectangle_overlap.sv =====
// Rotated rectangle overlap, top level.
// Depends on rro_pkg, rro_front, rro_fifo, rro_back.
//
// Input channel (req_*): one beat carries two rectangles (centre, full
// width/height in Q.8, 16-bit binary angle). Beat taken when push
// and !full.
// Result channel (rsp_*): one beat per request, rsp_overlaps = 1 when the
// rectangles intersect or touch. Oldest result shown while !empty,
// taken on pop.
// Path: front register at the accepting edge, then the work queue, the
// CORDIC pipe, 3 arithmetic stages and the result ring write.
// Throughput: one beat per cycle while full is low; the CORDIC pipe has one stage per step.
// The back pipe always runs; credits cover every beat in flight so the
// result queue never overflows. When the receiver stalls, full rises
// once queue plus in-flight beats reach the result queue size (32).
// Reset: synchronous; clears all valid bits and queue pointers.
module rotated_rectangle_overlap import rro_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic signed [CoordW-1:0] req_first_center_x,
   input  logic signed [CoordW-1:0] req_first_center_y,
   input  logic [CoordW-1:0]        req_first_width,
   input  logic [CoordW-1:0]        req_first_height,
   input  logic [AngleW-1:0]        req_first_angle,
   input  logic signed [CoordW-1:0] req_second_center_x,
   input  logic signed [CoordW-1:0] req_second_center_y,
   input  logic [CoordW-1:0]        req_second_width,
   input  logic [CoordW-1:0]        req_second_height,
   input  logic [AngleW-1:0]        req_second_angle,
   output logic                     empty,
   input  logic                     pop,
   output logic                     rsp_overlaps
);
   item_type item;
   logic     accept, fr_valid, bk_valid, bk_hit;
   work_type fr_work;
   logic [$bits(work_type):0] unused_q;
   logic [FifoCw-1:0] unused_c;
   logic [CredW-1:0] inflight_ff;
   logic rsp_take;

   // Result storage: 32-entry bit ring; pointers carry one wrap bit.
   logic [ResDepth-1:0] res_ff;
   logic [ResAw:0] rwr_ff, rrd_ff;

   assign accept = push && !full;
   assign full   = (inflight_ff == CredW'(ResDepth));
   assign rsp_take = pop && !empty;

   assign item = '{ax: req_first_center_x, ay: req_first_center_y,
                   wa: req_first_width, ha: req_first_height, ta: req_first_angle,
                   bx: req_second_center_x, by: req_second_center_y,
                   wb: req_second_width, hb: req_second_height, tb: req_second_angle};

   rro_front u_front (.clock(clock), .reset(reset), .in_valid(accept), .in_item(item),
                      .out_valid(fr_valid), .out_work(fr_work));

   // decoupling queue; back end never stalls so it drains every cycle
   logic wq_empty;
   rro_fifo u_wq (.clock(clock), .reset(reset), .push(fr_valid),
                  .push_data({1'b0, fr_work}), .pop(1'b1), .empty(wq_empty),
                  .count(unused_c), .pop_data(unused_q));

   rro_back u_back (.clock(clock), .reset(reset), .in_valid(!wq_empty),
                    .in_work(unused_q[$bits(work_type)-1:0]),
                    .out_valid(bk_valid), .out_hit(bk_hit));

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         rwr_ff <= '0;
         rrd_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + CredW'(accept) - CredW'(rsp_take);
         if (bk_valid) rwr_ff <= rwr_ff + 1'b1;
         if (rsp_take) rrd_ff <= rrd_ff + 1'b1;
      end
      if (bk_valid) res_ff[rwr_ff[ResAw-1:0]] <= bk_hit;
   end

   assign empty        = (rwr_ff == rrd_ff);
   assign rsp_overlaps = res_ff[rrd_ff[ResAw-1:0]];
endmodule

// ===== bench/rotated_rectangle_overlap_test.sv =====
// Testbench for rotated_rectangle_overlap: directed table, then random pairs,
// checked against fixed table bits or a built-in separating-axis predictor with CORDIC trig.
// Depends on rro_pkg and the block's RTL.
`timescale 1ns / 1ps

module rotated_rectangle_overlap_test import rro_pkg::*;;

   localparam int NumRandom  = 2000;
   localparam int DrainWait  = 40;
   localparam int KeepModel  = 2;    // table marker: use the predictor

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic empty;
   logic pop;
   logic rsp_overlaps;
   item_type req;

   // queue of expected overlap bits, oldest first
   bit   overlap_queue[$];
   int   fail_count;
   bit   stim_done;

   rotated_rectangle_overlap dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_first_center_x  (req.ax),
      .req_first_center_y  (req.ay),
      .req_first_width     (req.wa),
      .req_first_height    (req.ha),
      .req_first_angle     (req.ta),
      .req_second_center_x (req.bx),
      .req_second_center_y (req.by),
      .req_second_width    (req.wb),
      .req_second_height   (req.hb),
      .req_second_angle    (req.tb),
      .empty               (empty),
      .pop                 (pop),
      .rsp_overlaps        (rsp_overlaps)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   localparam longint AtanTab[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

   // angle in 2^32 per turn -> Q16 cosine and sine
   function automatic void rotate_unit(input logic [31:0] ang,
                                       output longint c_out, output longint s_out);
      logic [31:0] u;
      logic [1:0]  quad;
      longint x, y, z, xs, ys, c, s;
      u    = ang + 32'h20000000;
      quad = u[31:30];
      z    = longint'({2'b00, u[29:0]}) - 64'sh20000000;
      x    = 64'sh26DD3B6A;
      y    = 0;
      for (int i = 0; i < CordicSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - AtanTab[i];
         end else begin
            x = x + ys; y = y - xs; z = z + AtanTab[i];
         end
      end
      c = (x + 8192) >>> 14;
      s = (y + 8192) >>> 14;
      case (quad)
         2'd0: begin c_out = c;  s_out = s;  end
         2'd1: begin c_out = -s; s_out = c;  end
         2'd2: begin c_out = -c; s_out = -s; end
         default: begin c_out = s; s_out = -c; end
      endcase
   endfunction

   function automatic longint absval(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit predict_overlap(input item_type it);
      longint ca, sa, cb, sb, cd, sd, dx, dy, wa, ha, wb, hb, one;
      logic [31:0] ta32, tb32;
      bit hit;
      ta32 = {it.ta, 16'h0};
      tb32 = {it.tb, 16'h0};
      rotate_unit(ta32, ca, sa);
      rotate_unit(tb32, cb, sb);
      rotate_unit(tb32 - ta32, cd, sd);
      cd  = absval(cd);
      sd  = absval(sd);
      dx  = longint'(it.bx) - longint'(it.ax);
      dy  = longint'(it.by) - longint'(it.ay);
      wa  = longint'({40'h0, it.wa});
      ha  = longint'({40'h0, it.ha});
      wb  = longint'({40'h0, it.wb});
      hb  = longint'({40'h0, it.hb});
      one = 64'sd65536;
      hit = 1'b1;
      // separating axes: both edge normals of A, then both of B
      if (2 * absval(dx * ca + dy * sa) > wa * one + wb * cd + hb * sd) hit = 1'b0;
      if (2 * absval(-dx * sa + dy * ca) > ha * one + wb * sd + hb * cd) hit = 1'b0;
      if (2 * absval(dx * cb + dy * sb) > wb * one + wa * cd + ha * sd) hit = 1'b0;
      if (2 * absval(-dx * sb + dy * cb) > hb * one + wa * sd + ha * cd) hit = 1'b0;
      return hit;
   endfunction

   // ---------------------------------------------------------------
   // Directed table: expect is 0/1 where obvious, else KeepModel
   // ---------------------------------------------------------------
   typedef struct {
      item_type it;
      int       expect_bit;
   } table_row_type;

   table_row_type directed[$];

   task automatic add_row(input logic [23:0] ax, ay, wa, ha, input logic [15:0] ta,
                          input logic [23:0] bx, by, wb, hb, input logic [15:0] tb,
                          input int eb);
      table_row_type r;
      r.it = '{ax, ay, wa, ha, ta, bx, by, wb, hb, tb};
      r.expect_bit = eb;
      directed.push_back(r);
   endtask

   task automatic build_table();
      // two points at the origin touch
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      // identical unit squares
      add_row(0, 0, 256, 256, 0, 0, 0, 256, 256, 0, 1);
      // opposite corners of the coordinate range, degenerate: apart
      add_row(24'h800000, 24'h800000, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, 0);
      // maximal sizes everywhere, far centres, corners at the limit
      add_row(24'h800000, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
              24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, KeepModel);
      // squares exactly touching along an edge
      add_row(0, 0, 512, 512, 0, 512, 0, 512, 512, 0, 1);
      // squares one lsb apart
      add_row(0, 0, 512, 512, 0, 513, 0, 512, 512, 0, 0);
      // segment against a square, touching and missing
      add_row(0, 0, 512, 0, 0, 512, 0, 512, 512, 0, KeepModel);
      add_row(0, 0, 0, 512, 0, 600, 0, 100, 100, 0, 0);
      // point inside a rotated square
      add_row(10, 20, 0, 0, 0, 0, 0, 512, 512, 16'h2000, KeepModel);
      // 45 degree corner reaching out
      add_row(0, 0, 512, 512, 16'h2000, 600, 0, 256, 256, 0, KeepModel);
      add_row(0, 0, 512, 512, 16'h2000, 700, 0, 256, 256, 0, KeepModel);
      // quadrant angles and wrap
      add_row(0, 0, 1024, 256, 16'h4000, 0, 600, 256, 256, 0, KeepModel);
      add_row(0, 0, 1024, 256, 16'h8000, 600, 0, 256, 256, 16'hC000, KeepModel);
      add_row(0, 0, 1024, 256, 16'hC000, 0, 600, 256, 256, 16'h4000, KeepModel);
      add_row(0, 0, 1024, 256, 16'hFFFF, 700, 0, 256, 256, 16'h0001, KeepModel);
      // crossing thin bars
      add_row(0, 0, 4096, 16, 16'h1555, 0, 0, 4096, 16, 16'hAAAA, KeepModel);
      add_row(24'hFFFF00, 100, 3000, 10, 16'h3000, 50, 24'hFFFF80, 10, 3000, 16'h7123,
              KeepModel);
   endtask

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------
   int burst_left;

   // drive one beat; returns after the edge that takes it
   task automatic send_beat(input item_type it, input int eb);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      push <= 1'b1;
      req  <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      overlap_queue.push_back((eb == KeepModel) ? predict_overlap(it) : eb[0]);
      burst_left--;
   endtask

   function automatic logic [23:0] near_coord(input logic [23:0] base);
      return base + 24'($signed($urandom_range(0, 8192)) - 4096);
   endfunction

   function automatic item_type random_pair();
      item_type it;
      logic [23:0] cx, cy;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         // raw noise over every bit
         it = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         // nearby rectangles, sizes comparable to the spacing
         cx    = $urandom;
         cy    = $urandom;
         it.ax = near_coord(cx);
         it.ay = near_coord(cy);
         it.bx = near_coord(cx);
         it.by = near_coord(cy);
         it.wa = (mode == 2) ? 24'd0 : 24'($urandom_range(0, 8192));
         it.ha = 24'($urandom_range(0, 8192));
         it.wb = 24'($urandom_range(0, 8192));
         it.hb = (mode == 3) ? 24'd0 : 24'($urandom_range(0, 8192));
         it.ta = $urandom;
         it.tb = (mode == 4) ? it.ta : 16'($urandom);
      end
      return it;
   endfunction

   initial begin
      reset      <= 1'b1;
      push       <= 1'b0;
      req        <= '0;
      stim_done  = 1'b0;
      fail_count = 0;
      burst_left = 0;
      build_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_beat(directed[i].it, directed[i].expect_bit);
      for (int n = 0; n < NumRandom; n++) send_beat(random_pair(), KeepModel);
      push <= 1'b0;
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------
   // Receiver: stall pattern, with some stretches of steady pop
   // ---------------------------------------------------------------
   logic [15:0] stall_pattern;
   int          pattern_left;

   initial begin
      pop           <= 1'b0;
      stall_pattern = 16'hFFFF;
      pattern_left  = 0;
      forever begin
         @(posedge clock);
         if (pattern_left == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            pattern_left  = $urandom_range(16, 200);
         end
         pop           <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         pattern_left--;
      end
   end

   // result beats are checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (overlap_queue.size() == 0) begin
            $error("overlaps: unexpected beat, actual %0b", rsp_overlaps);
            fail_count++;
         end else begin
            if (rsp_overlaps !== overlap_queue[0]) begin
               $error("overlaps: expected %0b actual %0b", overlap_queue[0], rsp_overlaps);
               fail_count++;
            end
            void'(overlap_queue.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------
   // End of run
   // ---------------------------------------------------------------
   initial begin
      @(posedge clock);
      wait (stim_done);
      while (overlap_queue.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (fail_count == 0 && overlap_queue.size() == 0 && empty) begin
         $display("Verification passed");
      end else begin
         if (!empty) $error("overlaps: beat left over after drain");
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rro_pkg.sv
hdl/rro_front.sv
hdl/rro_fifo.sv
hdl/rro_cordic.sv
hdl/rro_back.sv
hdl/rotated_rectangle_overlap.sv
bench/rotated_rectangle_overlap_test.sv
